@@ design/lzss_bd_pkg.sv @@
// Shared types and constants for the LZSS block decoder.
// No dependencies; used by every module of the decoder.
`default_nettype none

package lzss_bd_pkg;

    localparam int HIST_AW        = 8;
    localparam int WINDOW_DEPTH   = 2 ** HIST_AW;
    localparam int HEADER_BYTES   = 4;
    localparam int HDR_POS_W      = 3;
    localparam int COUNT_W        = 8;
    localparam int LEN_W          = 5;
    localparam int LOOKBACK_CELLS = 2;

    localparam logic [HDR_POS_W-1:0] HDR_COUNT_POS = HDR_POS_W'(1);
    localparam logic [3:0]           HDR_END       = 4'(HEADER_BYTES);
    localparam logic [3:0]           FLAG_COUNT    = 4'd8;
    localparam logic [LEN_W-1:0]     MATCH_MIN     = LEN_W'(3);
    localparam logic [LEN_W-1:0]     MATCH_MAX     = LEN_W'(18);

    typedef struct packed {
        logic               we;
        logic [HIST_AW-1:0] addr;
        logic [7:0]         data;
    } hist_wr_t;

    typedef struct packed {
        logic               re;
        logic [HIST_AW-1:0] addr;
    } hist_rd_t;

    typedef struct packed {
        logic               valid;
        logic [HIST_AW-1:0] addr;
        logic [7:0]         data;
    } cell_t;

    typedef enum logic [3:0] {
        PH_HEADER = 4'b0001,
        PH_FLAG   = 4'b0010,
        PH_ITEM   = 4'b0100,
        PH_MATCH2 = 4'b1000
    } phase_t;

endpackage

`default_nettype wire

@@ design/lzss_block_decoder.sv @@
// LZSS block decoder top level: stream parser, match copy engine, output register.
// Depends on lzss_bd_pkg and lzss_bd_history.
//
// Takes one packed byte per request and gives decoded bytes on the result side.
// Header, flag and match-first bytes give no result; a literal gives one
// result. A match-second byte of length L (3 to 18, clipped to the bytes left
// in the block) holds the input until its copy is done: one history read per
// output byte through the single read port of the 256-byte window memory,
// plus the registered read. A stalled result side holds the copy in place.
// m_tuser carries block_end (bit 0) and overrun_error (bit 1); m_tlast marks
// the last byte caused by one input byte.
`default_nettype none

module lzss_block_decoder (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [7:0]  s_tdata,   // [7:0] in_byte
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [7:0]  m_tdata,   // [7:0] out_byte
    output logic        m_tlast,
    output logic [1:0]  m_tuser    // [0] block_end, [1] overrun_error
);

    localparam int AW  = lzss_bd_pkg::HIST_AW;
    localparam int CW  = lzss_bd_pkg::COUNT_W;
    localparam int LW  = lzss_bd_pkg::LEN_W;
    localparam int HPW = lzss_bd_pkg::HDR_POS_W;

    lzss_bd_pkg::phase_t   phase_reg, phase_next;
    logic [CW-1:0]         rc_reg, rc_next;
    logic [7:0]            flag_reg, flag_next;
    logic [3:0]            fbl_reg, fbl_next;
    logic [HPW-1:0]        hpos_reg, hpos_next;
    logic [LW-1:0]         pend_reg, pend_next;
    logic [AW-1:0]         wr_ptr_reg;

    logic [LW-1:0]         cp_cnt_reg, cp_cnt_next;
    logic [AW-1:0]         cp_addr_reg, cp_addr_next;
    logic                  cp_err_reg, cp_err_next;
    logic                  cp_end_reg, cp_end_next;

    logic                  b_valid_reg;
    logic                  b_last_reg, b_end_reg, b_err_reg;

    logic                  m_valid_reg;
    logic [7:0]            m_data_reg;
    logic                  m_last_reg, m_end_reg, m_err_reg;

    logic                  adv, busy, lit_emit, s_fire, lit_fire, a_fire, b_fire;
    logic                  out_load;
    logic [7:0]            load_data;
    logic                  load_last, load_end, load_err;
    logic [3:0]            pos_inc;
    logic [CW-1:0]         rc_hdr;
    logic [LW-1:0]         match_len;
    logic                  match_clip;
    logic [7:0]            hist_data;

    lzss_bd_pkg::hist_wr_t hw;
    lzss_bd_pkg::hist_rd_t hr;

    lzss_bd_history u_history (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr      (hw),
        .rd      (hr),
        .rd_data (hist_data)
    );

    assign adv      = !m_valid_reg || m_tready;
    assign busy     = (cp_cnt_reg != '0) || b_valid_reg;
    assign lit_emit = (phase_reg == lzss_bd_pkg::PH_ITEM) && (rc_reg != '0)
                      && (fbl_reg != '0) && !flag_reg[7];
    assign s_tready = !busy && (!lit_emit || adv);
    assign s_fire   = s_tvalid && s_tready;
    assign lit_fire = s_fire && lit_emit;
    assign a_fire   = (cp_cnt_reg != '0) && adv;
    assign b_fire   = b_valid_reg && adv;

    assign match_clip = {{(CW-LW){1'b0}}, pend_reg} > rc_reg;
    assign match_len  = match_clip ? rc_reg[LW-1:0] : pend_reg;
    assign pos_inc    = {1'b0, hpos_reg} + 4'd1;
    assign rc_hdr     = (hpos_reg == lzss_bd_pkg::HDR_COUNT_POS) ? s_tdata : rc_reg;

    // parser
    always_comb begin
        phase_next   = phase_reg;
        rc_next      = rc_reg;
        flag_next    = flag_reg;
        fbl_next     = fbl_reg;
        hpos_next    = hpos_reg;
        pend_next    = pend_reg;
        cp_cnt_next  = cp_cnt_reg;
        cp_addr_next = cp_addr_reg;
        cp_err_next  = cp_err_reg;
        cp_end_next  = cp_end_reg;
        if (a_fire) begin
            cp_cnt_next  = cp_cnt_reg - LW'(1);
            cp_addr_next = cp_addr_reg + AW'(1);
        end
        if (s_fire) begin
            unique case (phase_reg)
                lzss_bd_pkg::PH_HEADER: begin
                    rc_next = rc_hdr;
                    if (pos_inc >= lzss_bd_pkg::HDR_END) begin
                        hpos_next  = '0;
                        phase_next = (rc_hdr == '0) ? lzss_bd_pkg::PH_HEADER
                                                    : lzss_bd_pkg::PH_FLAG;
                    end else begin
                        hpos_next = pos_inc[HPW-1:0];
                    end
                end
                lzss_bd_pkg::PH_FLAG: begin
                    flag_next  = s_tdata;
                    fbl_next   = lzss_bd_pkg::FLAG_COUNT;
                    phase_next = lzss_bd_pkg::PH_ITEM;
                end
                lzss_bd_pkg::PH_ITEM: begin
                    priority if (rc_reg == '0) begin
                        phase_next = lzss_bd_pkg::PH_HEADER;
                        hpos_next  = '0;
                    end else if (fbl_reg == '0) begin
                        flag_next = s_tdata;
                        fbl_next  = lzss_bd_pkg::FLAG_COUNT;
                    end else if (!flag_reg[7]) begin
                        rc_next   = rc_reg - CW'(1);
                        flag_next = {flag_reg[6:0], 1'b0};
                        fbl_next  = fbl_reg - 4'd1;
                        priority if (rc_next == '0) begin
                            phase_next = lzss_bd_pkg::PH_HEADER;
                            hpos_next  = '0;
                        end else if (fbl_next == '0) begin
                            phase_next = lzss_bd_pkg::PH_FLAG;
                        end else begin
                            phase_next = lzss_bd_pkg::PH_ITEM;
                        end
                    end else begin
                        pend_next  = {1'b0, s_tdata[7:4]} + lzss_bd_pkg::MATCH_MIN;
                        phase_next = lzss_bd_pkg::PH_MATCH2;
                    end
                end
                lzss_bd_pkg::PH_MATCH2: begin
                    cp_cnt_next  = match_len;
                    cp_addr_next = wr_ptr_reg + ~s_tdata;
                    cp_err_next  = match_clip;
                    cp_end_next  = ({{(CW-LW){1'b0}}, match_len} == rc_reg);
                    rc_next      = rc_reg - {{(CW-LW){1'b0}}, match_len};
                    pend_next    = '0;
                    flag_next    = {flag_reg[6:0], 1'b0};
                    fbl_next     = (fbl_reg != '0) ? fbl_reg - 4'd1 : fbl_reg;
                    priority if (rc_next == '0) begin
                        phase_next = lzss_bd_pkg::PH_HEADER;
                        hpos_next  = '0;
                    end else if (fbl_next == '0) begin
                        phase_next = lzss_bd_pkg::PH_FLAG;
                    end else begin
                        phase_next = lzss_bd_pkg::PH_ITEM;
                    end
                end
                default: begin
                    phase_next = lzss_bd_pkg::PH_HEADER;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= lzss_bd_pkg::PH_HEADER;
            rc_reg      <= '0;
            flag_reg    <= '0;
            fbl_reg     <= '0;
            hpos_reg    <= '0;
            pend_reg    <= '0;
            cp_cnt_reg  <= '0;
            cp_err_reg  <= 1'b0;
            cp_end_reg  <= 1'b0;
            b_valid_reg <= 1'b0;
            wr_ptr_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            phase_reg   <= phase_next;
            rc_reg      <= rc_next;
            flag_reg    <= flag_next;
            fbl_reg     <= fbl_next;
            hpos_reg    <= hpos_next;
            pend_reg    <= pend_next;
            cp_cnt_reg  <= cp_cnt_next;
            cp_err_reg  <= cp_err_next;
            cp_end_reg  <= cp_end_next;
            if (adv) begin
                b_valid_reg <= a_fire;
            end
            if (hw.we) begin
                wr_ptr_reg <= wr_ptr_reg + AW'(1);
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        cp_addr_reg <= cp_addr_next;
        if (a_fire) begin
            b_last_reg <= (cp_cnt_reg == LW'(1));
            b_end_reg  <= cp_end_reg && (cp_cnt_reg == LW'(1));
            b_err_reg  <= cp_err_reg;
        end
        if (out_load) begin
            m_data_reg <= load_data;
            m_last_reg <= load_last;
            m_end_reg  <= load_end;
            m_err_reg  <= load_err;
        end
    end

    // history access and output register load
    always_comb begin
        out_load  = lit_fire || b_fire;
        load_data = lit_fire ? s_tdata : hist_data;
        load_last = lit_fire ? 1'b1 : b_last_reg;
        load_end  = lit_fire ? (rc_reg == CW'(1)) : b_end_reg;
        load_err  = lit_fire ? 1'b0 : b_err_reg;
        hw.we     = out_load;
        hw.addr   = wr_ptr_reg;
        hw.data   = load_data;
        hr.re     = a_fire;
        hr.addr   = cp_addr_reg;
    end

    assign m_tvalid   = m_valid_reg;
    assign m_tdata    = m_data_reg;
    assign m_tlast    = m_last_reg;
    assign m_tuser[0] = m_end_reg;
    assign m_tuser[1] = m_err_reg;

    a_no_request_while_copy: assert property (@(posedge aclk) disable iff (!aresetn)
        busy |-> !s_tready)
        else $error("input taken during match copy");

    a_single_writer: assert property (@(posedge aclk) disable iff (!aresetn)
        !(lit_fire && b_fire))
        else $error("literal and copy write collide");

    a_copy_len_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cp_cnt_reg <= lzss_bd_pkg::MATCH_MAX)
        else $error("copy count beyond longest match");

    a_copy_holds_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        b_valid_reg && !adv |=> b_valid_reg && $stable(cp_cnt_reg))
        else $error("copy advanced while output stalled");

endmodule

`default_nettype wire

@@ design/lzss_bd_cell.sv @@
// One lookback cell: holds a recent history write and hands it to its neighbor.
// Depends on lzss_bd_pkg.
`default_nettype none

module lzss_bd_cell (
    input  wire                                 aclk,
    input  wire                                 aresetn,
    input  wire                                 shift_en,
    input  lzss_bd_pkg::cell_t                  cell_in,
    input  wire [lzss_bd_pkg::HIST_AW-1:0]      probe_addr,
    output lzss_bd_pkg::cell_t                  cell_out,
    output logic                                hit
);

    logic                              valid_reg;
    logic [lzss_bd_pkg::HIST_AW-1:0]   addr_reg;
    logic [7:0]                        data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (shift_en) begin
            valid_reg <= cell_in.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (shift_en) begin
            addr_reg <= cell_in.addr;
            data_reg <= cell_in.data;
        end
    end

    assign cell_out.valid = valid_reg;
    assign cell_out.addr  = addr_reg;
    assign cell_out.data  = data_reg;
    assign hit            = valid_reg && (addr_reg == probe_addr);

endmodule

`default_nettype wire

@@ design/lzss_bd_history.sv @@
// History window: 256-byte memory with registered read and a chain of lookback
// cells that forwards writes the memory read has not yet seen. Uses lzss_bd_cell.
`default_nettype none

module lzss_bd_history (
    input  wire                    aclk,
    input  wire                    aresetn,
    input  lzss_bd_pkg::hist_wr_t  wr,
    input  lzss_bd_pkg::hist_rd_t  rd,
    output logic [7:0]             rd_data
);

    logic [7:0]                      mem [lzss_bd_pkg::WINDOW_DEPTH];
    logic [7:0]                      rd_data_reg;
    logic [lzss_bd_pkg::HIST_AW-1:0] rd_addr_reg;

    lzss_bd_pkg::cell_t              chain_in  [lzss_bd_pkg::LOOKBACK_CELLS];
    lzss_bd_pkg::cell_t              chain_out [lzss_bd_pkg::LOOKBACK_CELLS];
    logic [lzss_bd_pkg::LOOKBACK_CELLS-1:0] hits;

    always_ff @(posedge aclk) begin
        if (wr.we) begin
            mem[wr.addr] <= wr.data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd.re) begin
            rd_data_reg <= mem[rd.addr];
            rd_addr_reg <= rd.addr;
        end
    end

    assign chain_in[0].valid = 1'b1;
    assign chain_in[0].addr  = wr.addr;
    assign chain_in[0].data  = wr.data;

    for (genvar i = 0; i < lzss_bd_pkg::LOOKBACK_CELLS; i++) begin : g_cell
        if (i > 0) begin : g_link
            assign chain_in[i] = chain_out[i-1];
        end
        lzss_bd_cell u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .shift_en   (wr.we),
            .cell_in    (chain_in[i]),
            .probe_addr (rd_addr_reg),
            .cell_out   (chain_out[i]),
            .hit        (hits[i])
        );
    end

    // newest matching write wins
    always_comb begin
        rd_data = rd_data_reg;
        for (int i = lzss_bd_pkg::LOOKBACK_CELLS - 1; i >= 0; i--) begin
            if (hits[i]) begin
                rd_data = chain_out[i].data;
            end
        end
    end

endmodule

`default_nettype wire
